/* src/assert_macros.svh */
// ------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the peak decimator RTL
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define APD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("apd assertion failed");

// condition must never be seen at a clock edge out of reset
`define APD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("apd forbidden condition seen");

`else

`define APD_ASSERT(lbl, clk, rst_n, prop)
`define APD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* src/apd_pkg.sv */
// ------------------------------------------------------------------------
// apd_pkg
// Types and constants of the audio peak decimator
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package apd_pkg;

    // sizes
    localparam int MAX_CHANNELS  = 8;
    localparam int CH_BITS       = 3;
    localparam int SAMPLE_BITS   = 24;
    localparam int PEAK_MAX_BITS = SAMPLE_BITS - 1;
    localparam int CHUNK_BITS    = 17;
    localparam int CCNT_BITS     = 4;
    localparam int OUT_DATA_BITS = 48;

    // register reset values
    localparam logic [CHUNK_BITS-1:0] RESET_CHUNK_SIZE    = 17'd256;
    localparam logic [CCNT_BITS-1:0]  RESET_CHANNEL_COUNT = 4'd2;

    // register indexes
    localparam logic REG_CHUNK_SIZE    = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0]   t_sample;
    typedef logic        [PEAK_MAX_BITS-1:0] t_peak_max;
    typedef t_sample   [MAX_CHANNELS-1:0]    t_min_vec;
    typedef t_peak_max [MAX_CHANNELS-1:0]    t_max_vec;

    // control from the sequencer to the channel store
    typedef struct packed {
        logic               upd;
        logic               clr;
        logic [CH_BITS-1:0] ch;
    } t_store_ctrl;

endpackage

/* src/apd_peak_store.sv */
// ------------------------------------------------------------------------
// apd_peak_store
// Running min and max per channel, one compare-update per request
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module apd_peak_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  apd_pkg::t_store_ctrl i_ctrl,
    input  apd_pkg::t_sample     i_sample,
    output apd_pkg::t_min_vec    o_min_upd,
    output apd_pkg::t_max_vec    o_max_upd
);
    import apd_pkg::*;

    t_min_vec r_min;
    t_max_vec r_max;
    logic     s_nonneg;

    assign s_nonneg = ~i_sample[SAMPLE_BITS-1];

    // stores with the incoming sample folded into its channel
    always_comb begin
        o_min_upd = r_min;
        o_max_upd = r_max;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (i_ctrl.ch == CH_BITS'(i)) begin
                if (i_sample < r_min[i]) begin
                    o_min_upd[i] = i_sample;
                end
                if (s_nonneg && (i_sample[PEAK_MAX_BITS-1:0] > r_max[i])) begin
                    o_max_upd[i] = i_sample[PEAK_MAX_BITS-1:0];
                end
            end
        end
    end

    // clear at reset or chunk end, else keep the update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctrl.upd && i_ctrl.clr)) begin
            r_min <= '0;
            r_max <= '0;
        end else if (i_ctrl.upd) begin
            r_min <= o_min_upd;
            r_max <= o_max_upd;
        end
    end

endmodule

/* src/audio_peak_decimator_unit.sv */
// The first peak of a chunk is shown in the cycle after the request that ends it.
// Throughput: one sample per cycle; a chunk's burst drains one peak per cycle from a
// snapshot bank while tready is high; input only waits if a chunk ends during a burst.
// Reset (i_rst_n low at a clock edge) clears all peaks and positions and loads
// chunk_size 256 and channel_count 2.
// ------------------------------------------------------------------------
// audio_peak_decimator_unit
// Min/max peak decimation of an interleaved multi-channel sample stream
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module audio_peak_decimator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [apd_pkg::CHUNK_BITS-1:0]    i_cfg_data,
    // sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [apd_pkg::SAMPLE_BITS-1:0]   s_axis_tdata,   // [23:0] sample
    // peak stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [apd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,   // [23:0] peak_min,
                                                              // [46:24] peak_max, [47] 0
    output logic [apd_pkg::CH_BITS-1:0]       m_axis_tuser,   // [2:0] channel
    output logic                              m_axis_tlast    // last_of_run
);
    import apd_pkg::*;

    logic [CHUNK_BITS-1:0] r_chunk_size;
    logic [CCNT_BITS-1:0]  r_channel_count;
    logic [CH_BITS-1:0]    r_ch_pos;
    logic [CHUNK_BITS-1:0] r_frame_pos;

    logic                  r_busy;
    logic [CH_BITS-1:0]    r_out_ch;
    logic [CH_BITS-1:0]    r_out_last;
    t_min_vec              r_snap_min;
    t_max_vec              r_snap_max;

    logic [CCNT_BITS-1:0]  nch;
    logic [CCNT_BITS-1:0]  nch_m1;
    logic                  frame_end;
    logic [CHUNK_BITS-1:0] n_frame_pos;
    logic                  chunk_end;
    logic                  in_acc;
    logic                  out_acc;
    logic                  out_done;
    t_store_ctrl           store_ctrl;
    t_min_vec              min_upd;
    t_max_vec              max_upd;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size    <= RESET_CHUNK_SIZE;
            r_channel_count <= RESET_CHANNEL_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CHUNK_SIZE:    r_chunk_size    <= i_cfg_data;
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // active channel count, zero taken as one, clamped to the store depth
    always_comb begin
        if (r_channel_count == '0) begin
            nch = CCNT_BITS'(1);
        end else if (r_channel_count > CCNT_BITS'(MAX_CHANNELS)) begin
            nch = CCNT_BITS'(MAX_CHANNELS);
        end else begin
            nch = r_channel_count;
        end
    end
    assign nch_m1 = nch - CCNT_BITS'(1);

    // frame and chunk boundaries, from state only
    assign frame_end   = ({1'b0, r_ch_pos} + CCNT_BITS'(1)) >= nch;
    assign n_frame_pos = r_frame_pos + CHUNK_BITS'(1);
    assign chunk_end   = frame_end && (n_frame_pos >= r_chunk_size);

    // handshakes
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign out_done      = out_acc && m_axis_tlast;
    assign s_axis_tready = !chunk_end || !r_busy || out_done;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_pos    <= '0;
            r_frame_pos <= '0;
        end else if (in_acc) begin
            if (!frame_end) begin
                r_ch_pos <= r_ch_pos + CH_BITS'(1);
            end else begin
                r_ch_pos    <= '0;
                r_frame_pos <= chunk_end ? '0 : n_frame_pos;
            end
        end
    end

    // per-channel running peaks
    assign store_ctrl.upd = in_acc;
    assign store_ctrl.clr = chunk_end;
    assign store_ctrl.ch  = r_ch_pos;

    apd_peak_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (store_ctrl),
        .i_sample  (s_axis_tdata),
        .o_min_upd (min_upd),
        .o_max_upd (max_upd)
    );

    // burst control: capture at chunk end, drain one peak per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_out_ch   <= '0;
            r_out_last <= '0;
        end else if (in_acc && chunk_end) begin
            r_busy     <= 1'b1;
            r_out_ch   <= '0;
            r_out_last <= nch_m1[CH_BITS-1:0];
        end else if (out_done) begin
            r_busy <= 1'b0;
        end else if (out_acc) begin
            r_out_ch <= r_out_ch + CH_BITS'(1);
        end
    end

    // snapshot bank, head entry is the peak on the bus
    always_ff @(posedge i_clk) begin
        if (in_acc && chunk_end) begin
            r_snap_min <= min_upd;
            r_snap_max <= max_upd;
        end else if (out_acc) begin
            for (int i = 0; i < MAX_CHANNELS - 1; i++) begin
                r_snap_min[i] <= r_snap_min[i+1];
                r_snap_max[i] <= r_snap_max[i+1];
            end
        end
    end

    // peak stream
    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = {1'b0, r_snap_max[0], r_snap_min[0]};
    assign m_axis_tuser  = r_out_ch;
    assign m_axis_tlast  = (r_out_ch == r_out_last);

    // checks
    `APD_ASSERT(a_out_ch_range, i_clk, i_rst_n, r_busy |-> (r_out_ch <= r_out_last))
    `APD_ASSERT(a_no_overrun, i_clk, i_rst_n,
        (in_acc && chunk_end) |-> (!r_busy || out_done))
    `APD_ASSERT(a_burst_start, i_clk, i_rst_n,
        (in_acc && chunk_end) |=> (m_axis_tvalid && (m_axis_tuser == '0)))
    `APD_ASSERT(a_burst_end, i_clk, i_rst_n,
        (out_done && !(in_acc && chunk_end)) |=> !m_axis_tvalid)
    `APD_ASSERT_NEVER(a_peak_sign, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tdata[SAMPLE_BITS-1:0] != '0)
        && !m_axis_tdata[SAMPLE_BITS-1])

endmodule
